// File: src/assert_macros.svh
// Assertion macros used by the checker file rde_checker.sv.
// Expects signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define AST_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define AST_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

// File: src/rde_pkg.sv
// Shared types and constants of the memory delta run extractor.
// No dependencies; every other file but assert_macros.svh uses it.
`timescale 1ns / 1ps

package rde_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [11:0] WORD_BYTES      = 12'd2;
   localparam logic [11:0] RUN_OPEN_BYTES  = 12'd8;    // run header plus first word
   localparam logic [11:0] RUN_LEN_CAP     = 12'd4094;
   localparam logic [11:0] FILL_CAP        = 12'd4088;
   localparam logic [8:0]  GAP_STEP        = 9'd2;
   localparam logic [7:0]  GAP_SAT         = 8'd255;

   localparam logic [7:0]  GAP_LIMIT_RST   = 8'd12;
   localparam logic [11:0] MAX_RUN_RST     = 12'd1200;
   localparam logic [11:0] PKT_LIMIT_RST   = 12'd1286;

   typedef enum logic [1:0] {
      CSR_GAP_LIMIT = 2'd0,
      CSR_MAX_RUN   = 2'd1,
      CSR_PKT_LIMIT = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      REC_DATA    = 2'd0,
      REC_HEADER  = 2'd1,
      REC_PKT_END = 2'd2
   } rec_kind_type;

   typedef struct packed {
      logic [7:0]  gap_limit;
      logic [11:0] max_run;
      logic [11:0] pkt_limit;
   } cfg_type;

   // Up to three records caused by one item, always in data, header, end order.
   typedef struct packed {
      logic        has_data;
      logic [15:0] word;
      logic [15:0] addr;
      logic        shadow_write;
      logic        has_hdr;
      logic [16:0] run_start;
      logic [11:0] run_len;
      logic        has_end;
      logic [11:0] payload;
      logic        full;
   } bundle_type;

   typedef struct packed {
      logic has_space;
      logic not_empty;
   } q_status_type;

endpackage

// File: src/memory_delta_run_extractor.sv
// Top level of the memory delta run extractor: CSRs and the front/queue/back split.
// Depends on rde_pkg, rde_front, rde_queue and rde_back.
//
//   channel | direction | transaction carries
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | word, shadow copy, word address, last-of-extent flag
//   rsp_    | out       | one record: data word, run header or packet end
//   csr_    | in        | register index and write data
//
// Flow: a word giving n records holds the back end until all n are taken, and the
// four-entry bundle queue absorbs short bursts, so the front end takes one word per
// cycle until the queue fills.
// Path: a word's bundle is written into the queue, and each record is then loaded
// into the output register before it is offered on rsp_.
// Reset: synchronous, clears run/packet state, the queue and the output valid,
// and loads the register defaults (gap 12, max run 1200, packet limit 1286).
// Stalls: rsp_ready low holds the output register; req_ready drops only when
// the queue is full. csr_ready is always high.
`timescale 1ns / 1ps

module memory_delta_run_extractor (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_word_value,
   input  logic [15:0] req_shadow_value,
   input  logic [15:0] req_word_addr,
   input  logic        req_last_of_extent,
   // records
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_rec_kind,
   output logic [15:0] rsp_data_word,
   output logic [15:0] rsp_data_addr,
   output logic        rsp_shadow_write,
   output logic [16:0] rsp_run_start_byte,
   output logic [11:0] rsp_run_length_bytes,
   output logic [11:0] rsp_payload_bytes,
   output logic        rsp_packet_full,
   output logic        rsp_last,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   rde_pkg::cfg_type      cfg_ff, cfg_in;
   rde_pkg::q_status_type q_status;
   rde_pkg::bundle_type   push_bundle, head;
   logic                  push_valid, pop;

   // Accept register writes every cycle; an unknown index is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rde_pkg::CSR_GAP_LIMIT: cfg_in.gap_limit = csr_data[7:0];
            rde_pkg::CSR_MAX_RUN:   cfg_in.max_run   = csr_data;
            rde_pkg::CSR_PKT_LIMIT: cfg_in.pkt_limit = csr_data;
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_limit <= rde_pkg::GAP_LIMIT_RST;
         cfg_ff.max_run   <= rde_pkg::MAX_RUN_RST;
         cfg_ff.pkt_limit <= rde_pkg::PKT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each word and update run/packet state on accept.
   rde_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_status           (q_status),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_word_value     (req_word_value),
      .req_shadow_value   (req_shadow_value),
      .req_word_addr      (req_word_addr),
      .req_last_of_extent (req_last_of_extent),
      .push_valid         (push_valid),
      .push_bundle        (push_bundle)
   );

   // Hold bundles while the back end drains multi-record words.
   rde_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push_valid),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   // Back end: emit one record per cycle, in data, header, end order, while bundles wait and rsp_ready is high.
   rde_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .q_status             (q_status),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rec_kind         (rsp_rec_kind),
      .rsp_data_word        (rsp_data_word),
      .rsp_data_addr        (rsp_data_addr),
      .rsp_shadow_write     (rsp_shadow_write),
      .rsp_run_start_byte   (rsp_run_start_byte),
      .rsp_run_length_bytes (rsp_run_length_bytes),
      .rsp_payload_bytes    (rsp_payload_bytes),
      .rsp_packet_full      (rsp_packet_full),
      .rsp_last             (rsp_last)
   );

endmodule

// File: src/rde_front.sv
// Front end: accepts words, tracks run and packet state, builds result bundles.
// Depends on rde_pkg.
`timescale 1ns / 1ps

module rde_front (
   input  logic               clock,
   input  logic               reset,
   input  rde_pkg::cfg_type   cfg,
   input  rde_pkg::q_status_type q_status,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_word_value,
   input  logic [15:0]        req_shadow_value,
   input  logic [15:0]        req_word_addr,
   input  logic               req_last_of_extent,
   output logic               push_valid,
   output rde_pkg::bundle_type push_bundle
);

   logic [16:0] run_start_ff, run_start_in;
   logic [11:0] run_len_ff, run_len_in;
   logic [7:0]  gap_ff, gap_in;
   logic [11:0] fill_ff, fill_in;
   logic        skip_ff, skip_in;
   logic        accept;

   assign req_ready = q_status.has_space;
   assign accept    = req_valid && req_ready;

   always_comb begin : front_calc
      logic        changed;
      logic        full;
      logic [8:0]  gsum;
      rde_pkg::bundle_type b;

      changed      = (req_word_value != req_shadow_value);
      full         = 1'b0;
      gsum         = '0;
      b            = '0;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      gap_in       = gap_ff;
      fill_in      = fill_ff;
      skip_in      = skip_ff;

      if (accept) begin
         if (skip_ff) begin
            // drop the word; the extent end resumes normal work
            skip_in = !req_last_of_extent;
         end else begin
            if (run_len_ff != '0) begin
               run_len_in     = run_len_ff + rde_pkg::WORD_BYTES;
               fill_in        = fill_ff + rde_pkg::WORD_BYTES;
               b.has_data     = 1'b1;
               b.shadow_write = changed;
               if (changed) begin
                  gap_in = '0;
               end else begin
                  gsum   = {1'b0, gap_ff} + rde_pkg::GAP_STEP;
                  gap_in = gsum[8] ? rde_pkg::GAP_SAT : gsum[7:0];
               end
            end else if (changed) begin
               run_start_in   = {req_word_addr, 1'b0};
               run_len_in     = rde_pkg::WORD_BYTES;
               gap_in         = '0;
               fill_in        = fill_ff + rde_pkg::RUN_OPEN_BYTES;
               b.has_data     = 1'b1;
               b.shadow_write = 1'b1;
            end
            b.word = req_word_value;
            b.addr = req_word_addr;

            full = (fill_in >= cfg.pkt_limit) || (fill_in >= rde_pkg::FILL_CAP);

            b.run_start = run_start_in;
            b.run_len   = run_len_in;
            if (run_len_in != '0 && (full || gap_in > cfg.gap_limit ||
                run_len_in >= cfg.max_run || run_len_in >= rde_pkg::RUN_LEN_CAP)) begin
               b.has_hdr    = 1'b1;
               run_len_in   = '0;
               run_start_in = '0;
               gap_in       = '0;
            end

            b.payload = fill_in;
            if (full) begin
               b.has_end = 1'b1;
               b.full    = 1'b1;
               fill_in   = '0;
               skip_in   = !req_last_of_extent;
            end else if (req_last_of_extent) begin
               if (run_len_in != '0) begin
                  b.has_hdr    = 1'b1;
                  run_len_in   = '0;
                  run_start_in = '0;
               end
               b.has_end = (fill_in != '0);
               fill_in   = '0;
               gap_in    = '0;
            end
         end
      end

      if (!b.has_data) begin
         b.word         = '0;
         b.addr         = '0;
         b.shadow_write = 1'b0;
      end
      if (!b.has_hdr) begin
         b.run_start = '0;
         b.run_len   = '0;
      end
      if (!b.has_end) begin
         b.payload = '0;
      end

      push_bundle = b;
      push_valid  = accept && !skip_ff && (b.has_data || b.has_hdr || b.has_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= '0;
         run_len_ff   <= '0;
         gap_ff       <= '0;
         fill_ff      <= '0;
         skip_ff      <= 1'b0;
      end else begin
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         gap_ff       <= gap_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
      end
   end

endmodule

// File: src/rde_queue.sv
// Short bundle queue between the front end and the record emitter.
// Depends on rde_pkg.
`timescale 1ns / 1ps

module rde_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rde_pkg::bundle_type   push_bundle,
   input  logic                  pop,
   output rde_pkg::bundle_type   head,
   output rde_pkg::q_status_type status
);

   rde_pkg::bundle_type             entry_ff [rde_pkg::QUEUE_DEPTH];
   logic [rde_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rde_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rde_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_pop;

   localparam logic [rde_pkg::QPTR_W-1:0] PTR_LAST = rde_pkg::QPTR_W'(rde_pkg::QUEUE_DEPTH - 1);
   localparam logic [rde_pkg::QCNT_W-1:0] CNT_FULL = rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH);

   assign status.has_space = (count_ff != CNT_FULL);
   assign status.not_empty = (count_ff != '0);
   assign head             = entry_ff[rd_ptr_ff];
   assign do_pop           = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// File: src/rde_back.sv
// Back end: splits each queued bundle into records on a registered output.
// Depends on rde_pkg.
`timescale 1ns / 1ps

module rde_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rde_pkg::bundle_type   head,
   input  rde_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_rec_kind,
   output logic [15:0]           rsp_data_word,
   output logic [15:0]           rsp_data_addr,
   output logic                  rsp_shadow_write,
   output logic [16:0]           rsp_run_start_byte,
   output logic [11:0]           rsp_run_length_bytes,
   output logic [11:0]           rsp_payload_bytes,
   output logic                  rsp_packet_full,
   output logic                  rsp_last
);

   logic [2:0] taken_ff, taken_in;
   logic [2:0] pending, pick;
   logic       last_part, load;
   logic       valid_ff, valid_in;

   rde_pkg::rec_kind_type kind_ff, kind_in;
   logic [15:0] word_ff, addr_ff;
   logic        sw_ff, full_ff, last_ff;
   logic [16:0] start_ff;
   logic [11:0] len_ff, pay_ff;

   // bit 0 data, bit 1 header, bit 2 packet end
   assign pending   = {head.has_end, head.has_hdr, head.has_data} & ~taken_ff;
   assign pick      = pending & (~pending + 3'd1);
   assign last_part = ((pending & ~pick) == 3'd0);
   assign load      = q_status.not_empty && (!valid_ff || rsp_ready);
   assign pop       = load && last_part;

   always_comb begin
      taken_in = taken_ff;
      if (load) begin
         taken_in = last_part ? 3'd0 : (taken_ff | pick);
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      kind_in = rde_pkg::REC_DATA;
      unique case (pick)
         3'b001:  kind_in = rde_pkg::REC_DATA;
         3'b010:  kind_in = rde_pkg::REC_HEADER;
         3'b100:  kind_in = rde_pkg::REC_PKT_END;
         default: kind_in = rde_pkg::REC_DATA;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         taken_ff <= taken_in;
         valid_ff <= valid_in;
      end
   end

   // payload register, loaded with the next record
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         word_ff  <= pick[0] ? head.word : 16'd0;
         addr_ff  <= pick[0] ? head.addr : 16'd0;
         sw_ff    <= pick[0] && head.shadow_write;
         start_ff <= pick[1] ? head.run_start : 17'd0;
         len_ff   <= pick[1] ? head.run_len : 12'd0;
         pay_ff   <= pick[2] ? head.payload : 12'd0;
         full_ff  <= pick[2] && head.full;
         last_ff  <= last_part;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_rec_kind         = kind_ff;
   assign rsp_data_word        = word_ff;
   assign rsp_data_addr        = addr_ff;
   assign rsp_shadow_write     = sw_ff;
   assign rsp_run_start_byte   = start_ff;
   assign rsp_run_length_bytes = len_ff;
   assign rsp_payload_bytes    = pay_ff;
   assign rsp_packet_full      = full_ff;
   assign rsp_last             = last_ff;

endmodule

// File: src/rde_checker.sv
// Port-level checks on the memory delta run extractor, bound to the top level.
// Depends on rde_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_rec_kind,
   input logic [15:0] rsp_data_word,
   input logic        rsp_shadow_write,
   input logic [16:0] rsp_run_start_byte,
   input logic [11:0] rsp_run_length_bytes,
   input logic        rsp_packet_full,
   input logic        rsp_last
);

   // a packet end always closes the records of its word
   `AST_IMPLY(a_end_is_last, rsp_valid && rsp_rec_kind == rde_pkg::REC_PKT_END, rsp_last)
   // shadow writes only come with data records
   `AST_IMPLY(a_sw_on_data, rsp_valid && rsp_shadow_write,
      rsp_rec_kind == rde_pkg::REC_DATA)
   // a run header describes a real, word-aligned run
   `AST_IMPLY(a_hdr_sane, rsp_valid && rsp_rec_kind == rde_pkg::REC_HEADER,
      rsp_run_length_bytes != 12'd0 && !rsp_run_start_byte[0])
   // a full flag is only carried by packet ends
   `AST_IMPLY(a_full_on_end, rsp_valid && rsp_packet_full,
      rsp_rec_kind == rde_pkg::REC_PKT_END)
   // a stalled record holds
   `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data_word) && $stable(rsp_rec_kind))

endmodule

bind memory_delta_run_extractor rde_checker u_rde_checker (.*);

// File: tb/tb_memory_delta_run_extractor.sv
// Self-checking bench for memory_delta_run_extractor: directed and random word traffic,
// with every record checked against an in-bench prediction of runs and packets.
// Depends on rde_pkg and the memory_delta_run_extractor RTL.
`timescale 1ns / 1ps

module tb_memory_delta_run_extractor;

   localparam int DRAIN_CYCLES = 12;    // generous over the output latency plus queue
   localparam int QUIET_LIMIT  = 500;   // cycles with no transaction before giving up
   localparam int REPORT_MAX   = 10;

   // One record as it appears on the rsp_ channel.
   typedef struct packed {
      rde_pkg::rec_kind_type kind;
      logic [15:0]  word;
      logic [15:0]  addr;
      logic         shadow_write;
      logic [16:0]  run_start;
      logic [11:0]  run_len;
      logic [11:0]  payload;
      logic         full;
      logic         last;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_word_value = '0;
   logic [15:0] req_shadow_value = '0;
   logic [15:0] req_word_addr = '0;
   logic        req_last_of_extent = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_rec_kind;
   logic [15:0] rsp_data_word;
   logic [15:0] rsp_data_addr;
   logic        rsp_shadow_write;
   logic [16:0] rsp_run_start_byte;
   logic [11:0] rsp_run_length_bytes;
   logic [11:0] rsp_payload_bytes;
   logic        rsp_packet_full;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   // Shadow of the block's registers and run/packet state.
   logic [7:0]  gap_limit;
   logic [11:0] max_run_len;
   logic [11:0] packet_limit;
   logic [16:0] open_run_start;
   logic [11:0] open_run_len;
   logic [7:0]  gap_bytes;
   logic [11:0] packet_fill;
   logic        skip_to_extent_end;

   record_type  step_records[$];     // records caused by the word being predicted
   record_type  pending_records[$];  // records predicted but not yet seen
   int          fail_count = 0;
   logic        idling_on = 1'b1;    // random gaps on req_ and stalls on rsp_

   memory_delta_run_extractor dut (.*);

   initial forever #10 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic record_type data_record(input logic [15:0] w, a, input logic sw);
      record_type r;
      r = '0;
      r.kind = rde_pkg::REC_DATA;
      r.word = w;
      r.addr = a;
      r.shadow_write = sw;
      return r;
   endfunction

   function automatic record_type packet_end_record(input logic [11:0] fill, input logic full);
      record_type r;
      r = '0;
      r.kind = rde_pkg::REC_PKT_END;
      r.payload = fill;
      r.full = full;
      return r;
   endfunction

   // Emit the header of the open run and forget the run.
   function automatic void close_open_run();
      record_type r;
      r = '0;
      r.kind = rde_pkg::REC_HEADER;
      r.run_start = open_run_start;
      r.run_len = open_run_len;
      step_records.push_back(r);
      open_run_len = '0;
      open_run_start = '0;
      gap_bytes = '0;
   endfunction

   // Advance the predicted state by one accepted word and queue what it causes.
   function automatic void predict_word_records(input logic [15:0] w, s, a, input logic eoe);
      logic changed;
      logic full;
      changed = (w != s);
      step_records.delete();
      // Words of a skipped extent cause nothing; the final one ends the skip.
      if (skip_to_extent_end) begin
         if (eoe) skip_to_extent_end = 1'b0;
         return;
      end
      if (open_run_len != 0) begin
         open_run_len += rde_pkg::WORD_BYTES;
         packet_fill += rde_pkg::WORD_BYTES;
         step_records.push_back(data_record(w, a, changed));
         if (changed) gap_bytes = '0;
         else gap_bytes = (gap_bytes > 8'd253) ? rde_pkg::GAP_SAT : gap_bytes + 8'd2;
      end else if (changed) begin
         open_run_start = {1'b0, a} << 1;
         open_run_len = rde_pkg::WORD_BYTES;
         gap_bytes = '0;
         packet_fill += rde_pkg::RUN_OPEN_BYTES;
         step_records.push_back(data_record(w, a, 1'b1));
      end
      full = (packet_fill >= packet_limit) || (packet_fill >= rde_pkg::FILL_CAP);
      if (open_run_len != 0 && (full || gap_bytes > gap_limit ||
                                open_run_len >= max_run_len ||
                                open_run_len >= rde_pkg::RUN_LEN_CAP))
         close_open_run();
      if (full) begin
         step_records.push_back(packet_end_record(packet_fill, 1'b1));
         packet_fill = '0;
         if (!eoe) skip_to_extent_end = 1'b1;
      end else if (eoe) begin
         if (open_run_len != 0) close_open_run();
         if (packet_fill != 0) step_records.push_back(packet_end_record(packet_fill, 1'b0));
         packet_fill = '0;
         gap_bytes = '0;
      end
      if (step_records.size() > 0) step_records[$].last = 1'b1;
      foreach (step_records[i]) pending_records.push_back(step_records[i]);
   endfunction

   function automatic string record_text(input record_type r);
      return $sformatf("kind=%0d word=%h addr=%h sw=%0b start=%h len=%0d pay=%0d full=%0b last=%0b",
                       r.kind, r.word, r.addr, r.shadow_write, r.run_start, r.run_len,
                       r.payload, r.full, r.last);
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%t mismatch: %s", $realtime, msg);
   endfunction

   function automatic logic [15:0] flip_word(input logic [15:0] w);
      return w ^ 16'($urandom_range(1, 16'hFFFF));
   endfunction

   // ---------------------------------------------------------------- drivers

   // Drive one word, optionally after a random gap, and hold it until accepted.
   // Valid stays high on return so back-to-back words never drop it.
   task automatic send_word(input logic [15:0] word, shadow, addr, input logic eoe);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word_value <= word;
      req_shadow_value <= shadow;
      req_word_addr <= addr;
      req_last_of_extent <= eoe;
      do @(posedge clock); while (!req_ready);
      predict_word_records(word, shadow, addr, eoe);
   endtask

   // Drop valid, wait for every predicted record, then let the pipe settle.
   task automatic wait_for_results(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input rde_pkg::csr_idx_type idx, input logic [11:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rde_pkg::CSR_GAP_LIMIT: gap_limit = value[7:0];
         rde_pkg::CSR_MAX_RUN:   max_run_len = value;
         default:                packet_limit = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers only change once the block has gone idle.
   task automatic set_config(input logic [11:0] gap, run, pkt);
      wait_for_results(DRAIN_CYCLES);
      write_register(rde_pkg::CSR_GAP_LIMIT, gap);
      write_register(rde_pkg::CSR_MAX_RUN, run);
      write_register(rde_pkg::CSR_PKT_LIMIT, pkt);
   endtask

   // Receiver: ready high by default, with random stall bursts while idling is on.
   always @(negedge clock) begin
      int stall_left;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- checking

   // Compare each accepted record with the oldest prediction.
   always @(posedge clock) begin
      record_type seen;
      record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind = rde_pkg::rec_kind_type'(rsp_rec_kind);
         seen.word = rsp_data_word;
         seen.addr = rsp_data_addr;
         seen.shadow_write = rsp_shadow_write;
         seen.run_start = rsp_run_start_byte;
         seen.run_len = rsp_run_length_bytes;
         seen.payload = rsp_payload_bytes;
         seen.full = rsp_packet_full;
         seen.last = rsp_last;
         if (pending_records.size() == 0) begin
            note_failure({"unexpected record ", record_text(seen)});
         end else begin
            want = pending_records.pop_front();
            if (seen !== want)
               note_failure({"expected ", record_text(want), " got ", record_text(seen)});
         end
      end
   end

   // End the run if no transaction moves for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%t watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("tb_memory_delta_run_extractor: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // Reset register values: open, extend and gap-close a run, extreme fields,
   // an empty extent.
   task automatic test_basic_runs();
      send_word(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      // seven unchanged words: the seventh pushes the gap to 14 and closes the run
      for (int i = 1; i <= 7; i++)
         send_word(i[0] ? 16'h0000 : 16'hFFFF, i[0] ? 16'h0000 : 16'hFFFF, 16'(i), 1'b0);
      send_word(16'h7777, 16'h7777, 16'h0008, 1'b0);
      send_word(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(16'h1234, 16'h1234, 16'h5555, 1'b1);
      send_word(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
      send_word(16'h5555, 16'hAAAA, 16'hAAAB, 1'b1);
   endtask

   // Tiny limits: one-word runs, zero gap, full packets with and without skipping.
   task automatic test_small_limits();
      set_config(12'd0, 12'd0, 12'd1286);
      send_word(16'h0001, 16'h0000, 16'h0100, 1'b0);
      send_word(16'h8000, 16'h0000, 16'h0101, 1'b1);
      set_config(12'd0, 12'd1200, 12'd1286);
      send_word(16'h00FF, 16'hFF00, 16'h0200, 1'b0);
      send_word(16'h4242, 16'h4242, 16'h0201, 1'b0);
      send_word(16'h4343, 16'h4343, 16'h0202, 1'b1);
      // upper data bits of the gap write fall away, leaving 255
      set_config(12'hFFF, 12'd1, 12'd8);
      send_word(16'h1111, 16'h2222, 16'h0300, 1'b0);
      send_word(16'h3333, 16'h4444, 16'h0301, 1'b0);
      send_word(16'h5555, 16'h5555, 16'h0302, 1'b1);
      send_word(16'h6666, 16'h7777, 16'h0400, 1'b1);
      send_word(16'h8888, 16'h9999, 16'h0401, 1'b0);
      send_word(16'hAAAA, 16'hAAAA, 16'h0402, 1'b1);
      // zero packet limit: even a quiet word ends an empty packet as full
      set_config(12'd5, 12'd2, 12'd0);
      send_word(16'hBEEF, 16'hBEEF, 16'h0500, 1'b0);
      send_word(16'hCAFE, 16'hCAFE, 16'h0501, 1'b1);
   endtask

   // Drop the packet limit below the current fill while a run is open.
   task automatic test_limit_lowered();
      set_config(12'd12, 12'd1200, 12'd1286);
      for (int i = 0; i < 10; i++)
         send_word(16'(i * 16'h1357), 16'(i * 16'h1357) ^ 16'h0F0F, 16'(100 + i), 1'b0);
      set_config(12'd12, 12'd1200, 12'd8);
      send_word(16'h2020, 16'h2020, 16'd110, 1'b0);
      send_word(16'h3030, 16'h0303, 16'd111, 1'b1);
      send_word(16'h4040, 16'h0404, 16'd112, 1'b1);
   endtask

   // Random extents across several register settings; the last phase runs without idling.
   task automatic test_random_traffic();
      logic [15:0] base;
      logic [15:0] w;
      logic        chg;
      logic        pressure_done;
      logic [11:0] gap_pick;
      logic [11:0] run_pick;
      logic [11:0] pkt_pick;
      int          len;
      int          density;
      int          sent;
      pressure_done = 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case ($urandom_range(0, 2))
            0:       gap_pick = 12'd0;
            1:       gap_pick = 12'd255;
            default: gap_pick = 12'($urandom_range(0, 16));
         endcase
         case ($urandom_range(0, 3))
            0:       run_pick = 12'd2;
            1:       run_pick = 12'd4094;
            default: run_pick = 12'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 3))
            0:       pkt_pick = 12'd8;
            1:       pkt_pick = 12'd4095;
            default: pkt_pick = 12'($urandom_range(8, 120));
         endcase
         set_config(gap_pick, run_pick, pkt_pick);
         if (phase == 3) idling_on = 1'b0;
         sent = 0;
         while (sent < 12) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: unrelated word, random address and extent flag
               w = 16'($urandom);
               send_word(w, $urandom_range(0, 1) ? w : 16'($urandom), 16'($urandom),
                         1'($urandom));
               sent++;
            end else begin
               len = $urandom_range(1, 12);
               density = $urandom_range(0, 100);
               base = 16'($urandom);
               for (int i = 0; i < len; i++) begin
                  w = 16'($urandom);
                  chg = ($urandom_range(1, 100) <= density);
                  send_word(w, chg ? flip_word(w) : w, base + 16'(i), i == len - 1);
               end
               sent += len;
            end
            // hold the sender once until every predicted record has drained
            if (phase == 1 && !pressure_done) begin
               wait_for_results(0);
               pressure_done = 1'b1;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      gap_limit = rde_pkg::GAP_LIMIT_RST;
      max_run_len = rde_pkg::MAX_RUN_RST;
      packet_limit = rde_pkg::PKT_LIMIT_RST;
      open_run_start = '0;
      open_run_len = '0;
      gap_bytes = '0;
      packet_fill = '0;
      skip_to_extent_end = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_runs();
      test_small_limits();
      test_limit_lowered();
      test_random_traffic();
      wait_for_results(DRAIN_CYCLES);
      if (fail_count == 0 && pending_records.size() == 0)
         $display("tb_memory_delta_run_extractor: done, clean");
      else
         $display("tb_memory_delta_run_extractor: done, errors");
      $finish;
   end

endmodule
